FILE: hw/rtl/sitb_pkg.sv
// ---------------------------------------------------------------------------
// sitb_pkg
// Types, codes and the CRC helper shared by the selection information
// section builder.
// ---------------------------------------------------------------------------
`default_nettype none

package sitb_pkg;

  // Input operation codes.
  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_INFO_BYTE = 3'd1;
  localparam logic [2:0] OP_SERVICE   = 3'd2;
  localparam logic [2:0] OP_SVC_BYTE  = 3'd3;
  localparam logic [2:0] OP_FINISH    = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_VERSION      = 3'd0;
  localparam logic [2:0] REG_CURRENT_NEXT = 3'd1;
  localparam logic [2:0] REG_SECT_NUMBER  = 3'd2;
  localparam logic [2:0] REG_LAST_SECT    = 3'd3;
  localparam logic [2:0] REG_INFO_LEN     = 3'd4;
  localparam logic [2:0] REG_SERVICE_LEN  = 3'd5;

  // Section constants.
  localparam logic [7:0]  POINTER_BYTE  = 8'h00;
  localparam logic [7:0]  SIT_TID       = 8'h7F;
  localparam logic [7:0]  RESERVED_BYTE = 8'hFF;
  localparam logic [13:0] HDR_LEN_BASE  = 14'd11;
  localparam int          HDR_BYTES     = 11;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;

  // What one queued item turns into on the output side.
  typedef enum logic [1:0] {
    KIND_START,
    KIND_DATA,
    KIND_FINISH,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data_byte;
    logic [15:0] svc_ident;
    logic [2:0]  run_state;
    logic [11:0] svc_desc_len;
  } sitb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       status;
  } sitb_out_t;

  // A decoded item: the bytes it emits and how many of them there are.
  typedef struct packed {
    kind_t                       kind;
    logic [3:0]                  count;
    logic [HDR_BYTES-1:0][7:0]   bytes;
  } sitb_item_t;

  // MPEG-2 CRC32 update by one byte, most significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] acc;
    acc = c ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      acc = acc[31] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sitb_decode.sv
// ---------------------------------------------------------------------------
// sitb_decode
// Holds the configuration registers and the section-open flag, turns each
// accepted beat into a byte list, kept in the item register if it emits any.
// ---------------------------------------------------------------------------
`default_nettype none

module sitb_decode
  import sitb_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sitb_in_t    in_data,
  output logic             itm_valid,
  output sitb_item_t       itm,
  input  wire logic        itm_take
);

  localparam logic [13:0] MaxLenW = 14'(MAX_LEN);

  logic [4:0]  version_r;
  logic        current_next_r;
  logic [7:0]  sect_number_r;
  logic [7:0]  last_sect_r;
  logic [11:0] info_len_r;
  logic [11:0] svc_len_r;

  logic        running_r, running_nxt;
  logic        itm_valid_r, itm_valid_nxt;
  sitb_item_t  itm_r, itm_nxt;
  logic        produce;
  logic        accept;
  logic [13:0] sect_len;
  logic        len_err;

  // Register writes are always taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r      <= '0;
      current_next_r <= 1'b1;
      sect_number_r  <= '0;
      last_sect_r    <= '0;
      info_len_r     <= '0;
      svc_len_r      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VERSION:      version_r      <= cfg_data[4:0];
        REG_CURRENT_NEXT: current_next_r <= cfg_data[0];
        REG_SECT_NUMBER:  sect_number_r  <= cfg_data[7:0];
        REG_LAST_SECT:    last_sect_r    <= cfg_data[7:0];
        REG_INFO_LEN:     info_len_r     <= cfg_data;
        REG_SERVICE_LEN:  svc_len_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // A new beat is taken when the item register is empty or being emptied.
  assign in_ready = !itm_valid_r || itm_take;
  assign accept   = in_valid && in_ready;

  assign sect_len = HDR_LEN_BASE + 14'(info_len_r) + 14'(svc_len_r);
  assign len_err  = (sect_len > MaxLenW) || (14'(info_len_r) > MaxLenW);

  // Byte list for the incoming beat and the section-open flag that follows it.
  always_comb begin
    itm_nxt       = '0;
    itm_nxt.kind  = KIND_DATA;
    produce       = 1'b0;
    running_nxt   = running_r;
    case (in_data.op)
      OP_START: begin
        produce = 1'b1;
        if (len_err) begin
          itm_nxt.kind  = KIND_ERROR;
          itm_nxt.count = 4'd1;
          running_nxt   = 1'b0;
        end else begin
          itm_nxt.kind      = KIND_START;
          itm_nxt.count     = 4'(HDR_BYTES);
          itm_nxt.bytes[0]  = POINTER_BYTE;
          itm_nxt.bytes[1]  = SIT_TID;
          itm_nxt.bytes[2]  = {4'hF, sect_len[11:8]};
          itm_nxt.bytes[3]  = sect_len[7:0];
          itm_nxt.bytes[4]  = RESERVED_BYTE;
          itm_nxt.bytes[5]  = RESERVED_BYTE;
          itm_nxt.bytes[6]  = {2'b11, version_r, current_next_r};
          itm_nxt.bytes[7]  = sect_number_r;
          itm_nxt.bytes[8]  = last_sect_r;
          itm_nxt.bytes[9]  = {4'hF, info_len_r[11:8]};
          itm_nxt.bytes[10] = info_len_r[7:0];
          running_nxt       = 1'b1;
        end
      end
      OP_INFO_BYTE, OP_SVC_BYTE: begin
        produce          = running_r;
        itm_nxt.count    = 4'd1;
        itm_nxt.bytes[0] = in_data.data_byte;
      end
      OP_SERVICE: begin
        produce          = running_r;
        itm_nxt.count    = 4'd4;
        itm_nxt.bytes[0] = in_data.svc_ident[15:8];
        itm_nxt.bytes[1] = in_data.svc_ident[7:0];
        itm_nxt.bytes[2] = {1'b1, in_data.run_state, in_data.svc_desc_len[11:8]};
        itm_nxt.bytes[3] = in_data.svc_desc_len[7:0];
      end
      OP_FINISH: begin
        produce       = running_r;
        itm_nxt.kind  = KIND_FINISH;
        itm_nxt.count = 4'd4;
        running_nxt   = 1'b0;
      end
      default: ;
    endcase
  end

  // The item register is loaded only by beats that emit something.
  always_comb begin
    itm_valid_nxt = itm_valid_r;
    if (accept) begin
      itm_valid_nxt = produce;
    end else if (itm_take) begin
      itm_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      itm_valid_r <= 1'b0;
    end else begin
      itm_valid_r <= itm_valid_nxt;
      if (accept) begin
        running_r <= running_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      itm_r <= itm_nxt;
    end
  end

  assign itm_valid = itm_valid_r;
  assign itm       = itm_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sitb_emit.sv
// ---------------------------------------------------------------------------
// sitb_emit
// Walks the bytes of the current item one per cycle, when not stalled, into
// the output register, keeping the running CRC32 and supplying it on finish.
// ---------------------------------------------------------------------------
`default_nettype none

module sitb_emit
  import sitb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       itm_valid,
  input  wire sitb_item_t itm,
  output logic            itm_take,
  output logic            out_valid,
  input  wire logic       out_ready,
  output sitb_out_t       out_data
);

  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  sitb_out_t   out_data_r;
  logic        can_emit;
  logic        is_last;
  logic [7:0]  cur_byte;
  logic [7:0]  crc_sel;

  // An item's byte leaves when the output register is free or being drained.
  assign can_emit = itm_valid && (!out_valid_r || out_ready);
  assign is_last  = (idx_r == (itm.count - 4'd1));
  assign itm_take = can_emit && is_last;

  // CRC bytes go out most significant first.
  always_comb begin
    case (idx_r[1:0])
      2'd0:    crc_sel = crc_r[31:24];
      2'd1:    crc_sel = crc_r[23:16];
      2'd2:    crc_sel = crc_r[15:8];
      default: crc_sel = crc_r[7:0];
    endcase
  end

  assign cur_byte = (itm.kind == KIND_FINISH) ? crc_sel : itm.bytes[idx_r];

  // CRC update for the byte now leaving; the pointer field is not covered.
  always_comb begin
    crc_nxt = crc_r;
    case (itm.kind)
      KIND_START:  crc_nxt = (idx_r == 4'd0) ? CRC_INIT : crc_byte(crc_r, cur_byte);
      KIND_DATA:   crc_nxt = crc_byte(crc_r, cur_byte);
      KIND_FINISH: crc_nxt = is_last ? CRC_INIT : crc_r;
      KIND_ERROR:  crc_nxt = CRC_INIT;
      default:     crc_nxt = crc_r;
    endcase
  end

  assign idx_nxt = is_last ? 4'd0 : (idx_r + 4'd1);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (can_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (can_emit) begin
        idx_r <= idx_nxt;
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      out_data_r.out_byte <= cur_byte;
      out_data_r.last     <= is_last;
      out_data_r.status   <= (itm.kind == KIND_ERROR);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/dvb_sit_section_builder.sv
// ---------------------------------------------------------------------------
// dvb_sit_section_builder
// DVB selection information section builder with MPEG-2 CRC32.
// ---------------------------------------------------------------------------
// The block puts out one section byte per cycle while the output is not
// stalled. An input beat is decoded into the item register in the cycle it
// is accepted, and its bytes pass from there to the output register. The
// output byte rate sets the throughput: a start beat emits 11 bytes (one for
// a length error), a service entry or a finish beat 4, a descriptor byte 1;
// the next beat is accepted in the cycle the previous one's last byte enters
// the output register. Beats with no bytes leave the item register empty.
// Configuration registers should only be written while no section bytes
// are outstanding.
`default_nettype none

module dvb_sit_section_builder
  import sitb_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sitb_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output sitb_out_t        out_data
);

  logic       itm_valid;
  logic       itm_take;
  sitb_item_t itm;

  // Decode and item register.
  sitb_decode #(
    .MAX_LEN(MAX_LEN)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .itm_valid (itm_valid),
    .itm       (itm),
    .itm_take  (itm_take)
  );

  // Byte serialiser, CRC and output register.
  sitb_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .itm_valid (itm_valid),
    .itm       (itm),
    .itm_take  (itm_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/sitb_checker.sv
// ---------------------------------------------------------------------------
// sitb_checker
// Port-level checks on the section builder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module sitb_checker
  import sitb_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire sitb_out_t out_data
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // The error result is a single zero byte that closes its item.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last && (out_data.out_byte == 8'h00))
    else $error("malformed error result");

  // Nothing is shown straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An output beat never rises straight after reset is released.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n) && $past(rst_n, 2))
    else $error("output appeared too soon after reset");

endmodule

bind dvb_sit_section_builder sitb_checker u_sitb_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// Selection information section builder testbench
// Drives header settings through the register port and input beats through
// a valid/ready channel. Result beats are checked against a predictor of
// the section bytes and MPEG-2 CRC32, or a typed value. A short directed
// table leads, then random sections with random idling on both sides.
// ---------------------------------------------------------------------------
module testbench
  import sitb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN      = 1024;
  localparam int RAND_ITEMS   = 260;
  localparam int CALM_ITEMS   = 40;
  localparam int SETTLE       = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 7_000_000;

  // Register index that selects no register.
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam sitb_out_t ERR_RESULT = {8'h00, 1'b1, 1'b1};

  typedef enum {ROW_CFG, ROW_PRED, ROW_TYPED} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [11:0] val;
    sitb_in_t    item;
    int unsigned n_typed;
    sitb_out_t   typed_res;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  sitb_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  sitb_out_t out_data;

  // Header settings as the predictor sees them.
  logic [4:0]  hdr_version;
  logic        hdr_curnext;
  logic [7:0]  hdr_sect;
  logic [7:0]  hdr_last_sect;
  logic [11:0] info_len;
  logic [11:0] svc_total;

  // Predictor state.
  logic [31:0] sect_crc;
  bit          sect_open;

  sitb_out_t   pred_bytes[$];
  sitb_out_t   bytes_due[$];
  row_t        plan[$];

  int unsigned err_cnt = 0;
  int unsigned useful  = 0;
  bit          calm    = 1'b0;
  bit          hold_off = 1'b0;

  dvb_sit_section_builder #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // MPEG-2 CRC32, one bit at a time, most significant bit of the byte first.
  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int k = 7; k >= 0; k--) begin
      fb = r[31] ^ b[k];
      r  = {r[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input bit in_crc, input bit is_last);
    if (in_crc) begin
      sect_crc = crc_step(sect_crc, b);
    end
    pred_bytes.push_back({b, is_last, 1'b0});
  endfunction

  // Works out the result beats that one input beat causes.
  function automatic void predict_section_bytes(input sitb_in_t it);
    logic [13:0] sect_len;
    logic [7:0]  head [HDR_BYTES];
    pred_bytes.delete();
    if (it.op == OP_START) begin
      sect_len = 14'(HDR_BYTES) + {2'b00, info_len} + {2'b00, svc_total};
      sect_crc = CRC_INIT;
      if (sect_len > MAX_LEN || info_len > MAX_LEN) begin
        sect_open = 1'b0;
        pred_bytes.push_back(ERR_RESULT);
      end else begin
        sect_open = 1'b1;
        head[0]  = POINTER_BYTE;
        head[1]  = SIT_TID;
        head[2]  = {4'hF, sect_len[11:8]};
        head[3]  = sect_len[7:0];
        head[4]  = RESERVED_BYTE;
        head[5]  = RESERVED_BYTE;
        head[6]  = {2'b11, hdr_version, hdr_curnext};
        head[7]  = hdr_sect;
        head[8]  = hdr_last_sect;
        head[9]  = {4'hF, info_len[11:8]};
        head[10] = info_len[7:0];
        // The pointer field stays out of the CRC.
        for (int i = 0; i < HDR_BYTES; i++) begin
          push_byte(head[i], i != 0, i == HDR_BYTES - 1);
        end
      end
    end else if (sect_open) begin
      case (it.op)
        OP_INFO_BYTE, OP_SVC_BYTE: begin
          push_byte(it.data_byte, 1'b1, 1'b1);
        end
        OP_SERVICE: begin
          push_byte(it.svc_ident[15:8], 1'b1, 1'b0);
          push_byte(it.svc_ident[7:0], 1'b1, 1'b0);
          push_byte({1'b1, it.run_state, it.svc_desc_len[11:8]}, 1'b1, 1'b0);
          push_byte(it.svc_desc_len[7:0], 1'b1, 1'b1);
        end
        OP_FINISH: begin
          for (int i = 0; i < 4; i++) begin
            pred_bytes.push_back({sect_crc[31 - 8 * i -: 8], i == 3, 1'b0});
          end
          sect_crc  = CRC_INIT;
          sect_open = 1'b0;
        end
        default: begin
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Writes one register; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_VERSION:      hdr_version   = val[4:0];
      REG_CURRENT_NEXT: hdr_curnext   = val[0];
      REG_SECT_NUMBER:  hdr_sect      = val[7:0];
      REG_LAST_SECT:    hdr_last_sect = val[7:0];
      REG_INFO_LEN:     info_len      = val;
      REG_SERVICE_LEN:  svc_total     = val;
      default: begin
      end
    endcase
  endtask

  // Offers one input beat and records what it should produce.
  task automatic send_item(input sitb_in_t it, input bit use_typed,
                           input int unsigned n_typed, input sitb_out_t typed_res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_section_bytes(it);
    if (use_typed) begin
      if (n_typed != 0) begin
        bytes_due.push_back(typed_res);
        useful++;
      end
    end else begin
      foreach (pred_bytes[i]) bytes_due.push_back(pred_bytes[i]);
      if (pred_bytes.size() != 0) begin
        useful++;
      end
    end
  endtask

  // Lets every due beat arrive, then settles for beats with no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic sitb_in_t rand_item(input logic [2:0] op);
    sitb_in_t it;
    it.op           = op;
    it.data_byte    = 8'($urandom);
    it.svc_ident    = 16'($urandom);
    it.run_state    = 3'($urandom);
    it.svc_desc_len = 12'($urandom);
    return it;
  endfunction

  // Loop lengths: mostly small, sometimes near the length limit or anywhere.
  function automatic logic [11:0] pick_len();
    case ($urandom_range(0, 15))
      0: return 12'($urandom_range(0, 4095));
      1: begin
        case ($urandom_range(0, 4))
          0:       return 12'd0;
          1:       return 12'd1013;
          2:       return 12'd1024;
          3:       return 12'd1025;
          default: return 12'd4095;
        endcase
      end
      default: return 12'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic row_t cfg_row(input logic [2:0] idx, input logic [11:0] val);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, val: val, item: '0, n_typed: 0, typed_res: '0};
    return r;
  endfunction

  function automatic row_t item_row(input logic [2:0] op, input logic [7:0] db,
                                    input logic [15:0] sid, input logic [2:0] rs,
                                    input logic [11:0] slen);
    row_t r;
    r = '{kind: ROW_PRED, idx: '0, val: '0, item: {op, db, sid, rs, slen},
          n_typed: 0, typed_res: '0};
    return r;
  endfunction

  function automatic row_t typed_row(input row_t r, input int unsigned n,
                                     input sitb_out_t res);
    row_t t;
    t           = r;
    t.kind      = ROW_TYPED;
    t.n_typed   = n;
    t.typed_res = res;
    return t;
  endfunction

  // Directed table. Rows with a typed result are checked against that value.
  function automatic void load_plan();
    // Beats while no section is open, and unknown operations.
    plan.push_back(typed_row(item_row(OP_FINISH, 8'h00, 16'h0000, 3'd0, 12'h000), 0, '0));
    plan.push_back(typed_row(item_row(OP_INFO_BYTE, 8'hFF, 16'hFFFF, 3'd7, 12'hFFF), 0, '0));
    plan.push_back(typed_row(item_row(OP_SERVICE, 8'h5A, 16'hFFFF, 3'd7, 12'hFFF), 0, '0));
    plan.push_back(typed_row(item_row(OP_SVC_BYTE, 8'h00, 16'h0000, 3'd0, 12'h000), 0, '0));
    plan.push_back(typed_row(item_row(3'd5, 8'hFF, 16'hFFFF, 3'd7, 12'hFFF), 0, '0));
    plan.push_back(typed_row(item_row(3'd7, 8'h00, 16'h0000, 3'd0, 12'h000), 0, '0));
    // A section with the settings left by reset.
    plan.push_back(item_row(OP_START, 8'h00, 16'h0000, 3'd0, 12'h000));
    plan.push_back(typed_row(item_row(OP_INFO_BYTE, 8'h00, 16'hFFFF, 3'd7, 12'hFFF), 1,
                             {8'h00, 1'b1, 1'b0}));
    plan.push_back(typed_row(item_row(OP_SVC_BYTE, 8'hFF, 16'h0000, 3'd0, 12'h000), 1,
                             {8'hFF, 1'b1, 1'b0}));
    plan.push_back(item_row(OP_SERVICE, 8'h00, 16'hFFFF, 3'd7, 12'hFFF));
    plan.push_back(item_row(OP_SERVICE, 8'hFF, 16'h0000, 3'd0, 12'h000));
    plan.push_back(typed_row(item_row(3'd6, 8'hA5, 16'h1234, 3'd5, 12'h123), 0, '0));
    // A new start abandons the open section.
    plan.push_back(item_row(OP_START, 8'h00, 16'h0000, 3'd0, 12'h000));
    plan.push_back(item_row(OP_INFO_BYTE, 8'hA5, 16'h0000, 3'd0, 12'h000));
    plan.push_back(item_row(OP_FINISH, 8'h00, 16'h0000, 3'd0, 12'h000));
    // Header fields at their upper ends, section length exactly at the limit.
    plan.push_back(cfg_row(REG_VERSION, 12'd31));
    plan.push_back(cfg_row(REG_CURRENT_NEXT, 12'd0));
    plan.push_back(cfg_row(REG_SECT_NUMBER, 12'd255));
    plan.push_back(cfg_row(REG_LAST_SECT, 12'd255));
    plan.push_back(cfg_row(REG_INFO_LEN, 12'd1013));
    plan.push_back(cfg_row(REG_SERVICE_LEN, 12'd0));
    plan.push_back(cfg_row(REG_NONE, 12'hFFF));
    plan.push_back(item_row(OP_START, 8'h00, 16'h0000, 3'd0, 12'h000));
    plan.push_back(item_row(OP_SERVICE, 8'h00, 16'h1234, 3'd3, 12'h0AB));
    plan.push_back(item_row(OP_FINISH, 8'h00, 16'h0000, 3'd0, 12'h000));
    // Length errors, some followed by beats that must now be ignored.
    plan.push_back(cfg_row(REG_INFO_LEN, 12'd1014));
    plan.push_back(typed_row(item_row(OP_START, 8'h00, 16'h0000, 3'd0, 12'h000), 1,
                             ERR_RESULT));
    plan.push_back(typed_row(item_row(OP_FINISH, 8'h00, 16'h0000, 3'd0, 12'h000), 0, '0));
    plan.push_back(cfg_row(REG_INFO_LEN, 12'd1025));
    plan.push_back(typed_row(item_row(OP_START, 8'h00, 16'h0000, 3'd0, 12'h000), 1,
                             ERR_RESULT));
    plan.push_back(cfg_row(REG_INFO_LEN, 12'd0));
    plan.push_back(cfg_row(REG_SERVICE_LEN, 12'd4095));
    plan.push_back(typed_row(item_row(OP_START, 8'h00, 16'h0000, 3'd0, 12'h000), 1,
                             ERR_RESULT));
    plan.push_back(typed_row(item_row(OP_INFO_BYTE, 8'h11, 16'h0000, 3'd0, 12'h000), 0, '0));
    plan.push_back(cfg_row(REG_INFO_LEN, 12'd4095));
    plan.push_back(typed_row(item_row(OP_START, 8'h00, 16'h0000, 3'd0, 12'h000), 1,
                             ERR_RESULT));
    // Back to the lower ends.
    plan.push_back(cfg_row(REG_VERSION, 12'd0));
    plan.push_back(cfg_row(REG_CURRENT_NEXT, 12'd1));
    plan.push_back(cfg_row(REG_SECT_NUMBER, 12'd0));
    plan.push_back(cfg_row(REG_LAST_SECT, 12'd0));
    plan.push_back(cfg_row(REG_INFO_LEN, 12'd0));
    plan.push_back(cfg_row(REG_SERVICE_LEN, 12'd1013));
    plan.push_back(item_row(OP_START, 8'h00, 16'h0000, 3'd0, 12'h000));
    plan.push_back(item_row(OP_FINISH, 8'h00, 16'h0000, 3'd0, 12'h000));
  endfunction

  // New header settings for the next random section.
  task automatic random_config(input bit long_hold);
    bit any;
    any = 1'b0;
    wait_idle();
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_VERSION, 12'($urandom_range(0, 31)));
      any = 1'b1;
    end
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_CURRENT_NEXT, 12'($urandom_range(0, 1)));
      any = 1'b1;
    end
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_SECT_NUMBER, 12'($urandom_range(0, 255)));
      any = 1'b1;
    end
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_LAST_SECT, 12'($urandom_range(0, 255)));
      any = 1'b1;
    end
    if (long_hold) begin
      // Keep this section well inside the limit so that it produces beats.
      write_reg(REG_INFO_LEN, 12'd5);
      write_reg(REG_SERVICE_LEN, 12'd20);
      any = 1'b1;
    end else begin
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_INFO_LEN, pick_len());
        any = 1'b1;
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_SERVICE_LEN, pick_len());
        any = 1'b1;
      end
    end
    if (!any) begin
      write_reg(REG_INFO_LEN, pick_len());
    end
    cfg_valid <= 1'b0;
  endtask

  // One random section: mostly well formed, sometimes noise or broken.
  task automatic random_section(input bit long_hold);
    int unsigned shape;
    int unsigned n_info;
    int unsigned n_svc;
    shape = long_hold ? 9 : $urandom_range(0, 9);
    random_config(long_hold);
    if (shape == 0) begin
      repeat ($urandom_range(3, 8)) begin
        send_item(rand_item(3'($urandom_range(0, 7))), 1'b0, 0, '0);
      end
    end else begin
      send_item(rand_item(OP_START), 1'b0, 0, '0);
      if (long_hold) begin
        hold_off = 1'b1;
      end
      n_info = long_hold ? 30 : $urandom_range(0, 6);
      repeat (n_info) begin
        if ($urandom_range(0, 11) == 0) begin
          send_item(rand_item(3'($urandom_range(5, 7))), 1'b0, 0, '0);
        end
        send_item(rand_item(OP_INFO_BYTE), 1'b0, 0, '0);
      end
      // A restart in the middle of the section.
      if (shape == 2) begin
        send_item(rand_item(OP_START), 1'b0, 0, '0);
      end
      n_svc = $urandom_range(0, 3);
      repeat (n_svc) begin
        send_item(rand_item(OP_SERVICE), 1'b0, 0, '0);
        repeat ($urandom_range(0, 4)) begin
          send_item(rand_item(OP_SVC_BYTE), 1'b0, 0, '0);
        end
      end
      // Shape 1 leaves the section open for the next start to abandon.
      if (shape != 1) begin
        send_item(rand_item(OP_FINISH), 1'b0, 0, '0);
      end
    end
  endtask

  // Result side: random ready bursts, one long hold-off, none at the end.
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Each result beat is compared with the oldest due beat.
  always @(posedge clk) begin
    sitb_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (bytes_due.size() == 0) begin
        report_mismatch("result beat with none due, out_byte", out_data.out_byte, 8'h00);
      end else begin
        want = bytes_due.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          report_mismatch("out_byte", out_data.out_byte, want.out_byte);
        end
        if (out_data.last !== want.last) begin
          report_mismatch("last", 8'(out_data.last), 8'(want.last));
        end
        if (out_data.status !== want.status) begin
          report_mismatch("status", 8'(out_data.status), 8'(want.status));
        end
      end
    end
  end

  // Main sequence: reset, directed table, random sections, drain.
  initial begin
    row_t r;
    bit   cfg_open;
    int unsigned phase;
    cfg_open  = 1'b0;
    phase     = 0;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    // Predictor settings after reset.
    hdr_version   = '0;
    hdr_curnext   = 1'b1;
    hdr_sect      = '0;
    hdr_last_sect = '0;
    info_len      = '0;
    svc_total     = '0;
    sect_crc      = CRC_INIT;
    sect_open     = 1'b0;
    load_plan();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_CFG) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
        end
        write_reg(r.idx, r.val);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(r.item, r.kind == ROW_TYPED, r.n_typed, r.typed_res);
      end
    end

    useful = 0;
    while (useful < RAND_ITEMS) begin
      if (useful >= RAND_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      random_section(phase == 3);
      phase++;
    end

    in_valid <= 1'b0;
    calm = 1'b1;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sitb_pkg.sv
hw/rtl/sitb_decode.sv
hw/rtl/sitb_emit.sv
hw/rtl/dvb_sit_section_builder.sv
hw/rtl/sitb_checker.sv
tb/sv/testbench.sv
